// File: rtl/utf8dec_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and status codes for the UTF-8 decoder core.
// Used by every module of the core; depends on nothing else.
package utf8dec_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int UNIT_W      = 21;
	localparam int OUTQ_DEPTH  = 4;
	localparam int OUTQ_AW     = $clog2(OUTQ_DEPTH);

	// Status codes carried in status words.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_STRAY     = 3'd1;
	localparam logic [2:0] ST_MISSING   = 3'd2;
	localparam logic [2:0] ST_SURROGATE = 3'd3;
	localparam logic [2:0] ST_TOO_BIG   = 3'd4;
	localparam logic [2:0] ST_CAPACITY  = 3'd5;
	localparam logic [2:0] ST_TRUNCATED = 3'd6;

	// Register indexes on the APB port.
	localparam logic REG_FORMAT   = 1'b0;
	localparam logic REG_CAPACITY = 1'b1;

	localparam logic FMT_UTF32 = 1'b0;
	localparam logic FMT_UTF16 = 1'b1;

	typedef struct packed {
		logic        output_format;
		logic [15:0] unit_capacity;
	} cfg_t;

	typedef struct packed {
		logic [UNIT_W-1:0] code_unit;
		logic              status_item;
		logic [2:0]        status_code;
		logic [15:0]       unit_count;
		logic              last_of_run;
	} item_t;

	typedef struct packed {
		logic [1:0] n;      // number of words produced, 0 to 2
		item_t      item0;
		item_t      item1;
	} result_t;

endpackage

// File: rtl/utf8_to_utf32_or_utf16_core.sv
`timescale 1ns / 1ps
// Top level of the UTF-8 to UTF-32 / UTF-16 decoder core.
// Depends on utf8dec_pkg, utf8dec_regs, utf8dec_decode and utf8dec_outq.
//
// Usage: the slave stream carries one UTF-8 byte per word in s_axis_tdata;
// s_axis_tuser high marks the end of a string and carries no byte. The
// master stream gives code units, and for every end marker one status word
// (m_axis_tuser high) with the status code and the unit count of the string.
// m_axis_tlast is high on the last word caused by an input word.
// The APB port holds the output format (address 0) and the unit capacity
// (address 4); write them only while the core is idle.
// Path: an input word is taken into the input register, then decoded into the
// result queue once the queue has room; its result words are offered from there.
// Throughput: one input word per cycle while each gives at most one result
// and the receiver is ready; a surrogate pair leaves as two words. Rate is
// set by the single-word read port of the four-entry result queue.
// Reset clears the string state, the queue and both registers. When the
// receiver stalls, the queue fills and s_axis_tready drops once fewer than
// two free entries remain; no word is lost.
module utf8_to_utf32_or_utf16_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] end_mark
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [20:0] code_unit, [23:21] status_code, [39:24] unit_count
	output logic        m_axis_tuser,   // [0] status_item
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import utf8dec_pkg::*;

	cfg_t       cfg;
	result_t    res;
	item_t      out_item;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       room;
	logic       advance;
	logic       in_fire;

	assign advance       = valid_s1 & room;
	assign s_axis_tready = !valid_s1 | room;
	assign in_fire       = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_fire)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tuser;
		end
	end

	utf8dec_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	utf8dec_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.end_s1  (end_s1),
		.cfg     (cfg),
		.res     (res)
	);

	utf8dec_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.res       (res),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (out_item)
	);

	assign m_axis_tdata = {out_item.unit_count, out_item.status_code, out_item.code_unit};
	assign m_axis_tuser = out_item.status_item;
	assign m_axis_tlast = out_item.last_of_run;

endmodule

// File: rtl/utf8dec_regs.sv
`timescale 1ns / 1ps
// APB configuration registers of the UTF-8 decoder core: output format and
// unit capacity. Depends on utf8dec_pkg.
module utf8dec_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output utf8dec_pkg::cfg_t   cfg
);
	import utf8dec_pkg::*;

	logic        format_q;
	logic [15:0] capacity_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q   <= FMT_UTF32;
			capacity_q <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_FORMAT:   format_q   <= pwdata[0];
				REG_CAPACITY: capacity_q <= pwdata[15:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FORMAT:   prdata = {31'd0, format_q};
			REG_CAPACITY: prdata = {16'd0, capacity_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.output_format = format_q;
	assign cfg.unit_capacity = capacity_q;

endmodule

// File: rtl/utf8dec_decode.sv
`timescale 1ns / 1ps
// Decode stage: holds the per-string state and turns one registered input
// word into up to two result words. Depends on utf8dec_pkg.
module utf8dec_decode (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic [7:0]             byte_s1,
	input  logic                   end_s1,
	input  utf8dec_pkg::cfg_t      cfg,
	output utf8dec_pkg::result_t   res
);
	import utf8dec_pkg::*;

	localparam int SUM_W = COUNT_WIDTH + 18;
	localparam logic [SUM_W-1:0] CNT_MAX = SUM_W'((64'd1 << COUNT_WIDTH) - 64'd1);

	logic [1:0]             pend_q, pend_d;
	logic [UNIT_W-1:0]      cp_q, cp_d;
	logic [2:0]             err_q, err_d;
	logic [COUNT_WIDTH-1:0] units_q, units_d;

	logic [UNIT_W-1:0]      cp_cont;
	logic [1:0]             pend_dec;
	logic [UNIT_W-1:0]      fin_u0, fin_u1;
	logic [1:0]             fin_n;
	logic [2:0]             fin_err;
	logic [UNIT_W-1:0]      em_u0, em_u1;
	logic [1:0]             em_n;
	logic                   want_emit;
	logic [SUM_W-1:0]       sum;
	logic                   cap_hit;
	logic [19:0]            offset;
	logic [2:0]             end_code;
	logic [15:0]            end_count;

	assign cp_cont  = {cp_q[UNIT_W-7:0], byte_s1[5:0]};
	assign pend_dec = pend_q - 2'd1;
	assign offset   = 20'(cp_cont - 21'h010000);

	// Checks on a completed code point and the units it becomes.
	always_comb begin
		fin_u0  = cp_cont;
		fin_u1  = '0;
		fin_n   = 2'd1;
		fin_err = ST_OK;
		if (cfg.output_format == FMT_UTF32) begin
			if (cp_cont >= 21'h00D800 && cp_cont < 21'h00E000) begin
				fin_err = ST_SURROGATE;
				fin_n   = 2'd0;
			end
		end else if (cp_cont > 21'h10FFFF) begin
			fin_err = ST_TOO_BIG;
			fin_n   = 2'd0;
		end else if (cp_cont > 21'h00FFFF) begin
			fin_u0 = 21'h00D800 + 21'(offset[19:10]);
			fin_u1 = 21'h00DC00 | 21'(cp_cont[9:0]);
			fin_n  = 2'd2;
		end else if (cp_cont >= 21'h00D800 && cp_cont < 21'h00E000) begin
			fin_err = ST_SURROGATE;
			fin_n   = 2'd0;
		end
	end

	// Select what the byte wants to emit, then apply the capacity check once.
	always_comb begin
		want_emit = 1'b0;
		em_u0     = fin_u0;
		em_u1     = fin_u1;
		em_n      = fin_n;
		if (!end_s1 && err_q == ST_OK) begin
			if (pend_q == 2'd0) begin
				if (byte_s1 < 8'h80) begin
					want_emit = 1'b1;
					em_u0     = 21'(byte_s1);
					em_u1     = '0;
					em_n      = 2'd1;
				end
			end else if (byte_s1[7:6] == 2'b10 && pend_dec == 2'd0 && fin_n != 2'd0) begin
				want_emit = 1'b1;
			end
		end
	end

	assign sum     = SUM_W'(units_q) + SUM_W'(em_n);
	assign cap_hit = (cfg.unit_capacity != 16'd0) && (sum >= SUM_W'(cfg.unit_capacity));

	always_comb begin
		if (err_q != ST_OK)
			end_code = err_q;
		else if (pend_q != 2'd0)
			end_code = ST_TRUNCATED;
		else
			end_code = ST_OK;
		if (end_code != ST_OK)
			end_count = '0;
		else if (SUM_W'(units_q) > SUM_W'(17'h0FFFF))
			end_count = 16'hFFFF;
		else
			end_count = 16'(units_q);
	end

	always_comb begin
		pend_d  = pend_q;
		cp_d    = cp_q;
		err_d   = err_q;
		units_d = units_q;
		res     = '0;
		if (end_s1) begin
			res.n                 = 2'd1;
			res.item0.status_item = 1'b1;
			res.item0.status_code = end_code;
			res.item0.unit_count  = end_count;
			res.item0.last_of_run = 1'b1;
			pend_d  = '0;
			cp_d    = '0;
			err_d   = ST_OK;
			units_d = '0;
		end else if (err_q == ST_OK) begin
			if (pend_q == 2'd0) begin
				if (byte_s1 >= 8'hF0) begin
					cp_d   = 21'(byte_s1[2:0]);
					pend_d = 2'd3;
				end else if (byte_s1 >= 8'hE0) begin
					cp_d   = 21'(byte_s1[3:0]);
					pend_d = 2'd2;
				end else if (byte_s1 >= 8'hC0) begin
					cp_d   = 21'(byte_s1[4:0]);
					pend_d = 2'd1;
				end else if (byte_s1 >= 8'h80) begin
					err_d = ST_STRAY;
				end
			end else if (byte_s1[7:6] != 2'b10) begin
				err_d  = ST_MISSING;
				pend_d = '0;
			end else begin
				cp_d   = cp_cont;
				pend_d = pend_dec;
				if (pend_dec == 2'd0 && fin_n == 2'd0)
					err_d = fin_err;
			end
			if (want_emit) begin
				if (cap_hit) begin
					err_d = ST_CAPACITY;
				end else begin
					res.n               = em_n;
					res.item0.code_unit = em_u0;
					res.item1.code_unit = em_u1;
					if (em_n == 2'd2)
						res.item1.last_of_run = 1'b1;
					else
						res.item0.last_of_run = 1'b1;
					units_d = (sum > CNT_MAX) ? COUNT_WIDTH'(CNT_MAX) : COUNT_WIDTH'(sum);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			cp_q    <= '0;
			err_q   <= ST_OK;
			units_q <= '0;
		end else if (advance) begin
			pend_q  <= pend_d;
			cp_q    <= cp_d;
			err_q   <= err_d;
			units_q <= units_d;
		end
	end

endmodule

// File: rtl/utf8dec_outq.sv
`timescale 1ns / 1ps
// Result queue of the UTF-8 decoder core: takes up to two words a cycle
// and hands out one while the receiver is ready. Depends on utf8dec_pkg.
module utf8dec_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  utf8dec_pkg::result_t  res,
	output logic                  room,
	output logic                  out_valid,
	input  logic                  out_ready,
	output utf8dec_pkg::item_t    out_item
);
	import utf8dec_pkg::*;

	item_t                entry_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [OUTQ_AW:0]     count_q;
	logic [1:0]           n_push;
	logic                 pop;

	assign n_push    = push ? res.n : 2'd0;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid & out_ready;
	// A pair of words must always fit, whatever the receiver does.
	assign room      = (count_q <= (OUTQ_AW+1)'(OUTQ_DEPTH - 2));
	assign out_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			entry_q[wr_ptr_q] <= res.item0;
		if (n_push == 2'd2)
			entry_q[wr_ptr_q + OUTQ_AW'(1)] <= res.item1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUTQ_AW'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + OUTQ_AW'(1);
			count_q <= count_q + (OUTQ_AW+1)'(n_push) - (OUTQ_AW+1)'(pop);
		end
	end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for utf8_to_utf32_or_utf16_core: directed table, then random strings.
// Depends on utf8dec_pkg and the core; expected words come from a behavioural decoder below.
module testbench;
	import utf8dec_pkg::*;

	localparam int LIMIT_CYCLES  = 2_000_000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_WORDS   = 165;
	localparam int MAX_PRINTS    = 200;

	typedef enum logic [1:0] {ROW_BYTE, ROW_END, ROW_FORMAT, ROW_CAPACITY} row_kind_e;

	typedef struct packed {
		row_kind_e   kind;
		logic [15:0] value;
		logic        pinned;
		logic [20:0] unit;
		logic [2:0]  code;
		logic [15:0] count;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
	logic        s_axis_tuser = 1'b0;    // [0] end_mark
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;           // [20:0] code_unit, [23:21] status_code, [39:24] unit_count
	logic        m_axis_tuser;           // [0] status_item
	logic        m_axis_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// Typed expectation that travels with a directed word.
	logic  drv_pinned = 1'b0;
	item_t drv_typed = '0;

	int send_idle = 0;
	int recv_idle = 0;
	int words_sent = 0;
	int mismatches = 0;
	int cycle_count = 0;

	// Decoder mirror: register copies and string state.
	logic        fmt_mirror = FMT_UTF32;
	logic [15:0] cap_mirror = 16'd0;
	logic [1:0]  pend_bytes = 2'd0;
	logic [20:0] cp_acc = 21'd0;
	logic [2:0]  err_latched = ST_OK;
	logic [15:0] unit_tally = 16'd0;

	item_t fresh_units[$];
	item_t expected_units[$];

	stim_row_t directed_rows [31] = '{
		'{ROW_BYTE,     16'h00,   1'b1, 21'h00,     ST_OK,        16'd0},
		'{ROW_BYTE,     16'h7F,   1'b1, 21'h7F,     ST_OK,        16'd0},
		'{ROW_BYTE,     16'hFF,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_BYTE,     16'hBF,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_BYTE,     16'hBF,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_BYTE,     16'hBF,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_END,      16'h00,   1'b1, 21'h0,      ST_OK,        16'd3},
		'{ROW_BYTE,     16'h80,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_END,      16'h00,   1'b1, 21'h0,      ST_STRAY,     16'd0},
		'{ROW_BYTE,     16'hE0,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_BYTE,     16'h41,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_END,      16'h00,   1'b1, 21'h0,      ST_MISSING,   16'd0},
		'{ROW_BYTE,     16'hED,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_BYTE,     16'hA0,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_BYTE,     16'h80,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_END,      16'h00,   1'b1, 21'h0,      ST_SURROGATE, 16'd0},
		'{ROW_BYTE,     16'hC3,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_END,      16'h00,   1'b1, 21'h0,      ST_TRUNCATED, 16'd0},
		'{ROW_FORMAT,   16'd1,    1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_CAPACITY, 16'd3,    1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_BYTE,     16'hF0,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_BYTE,     16'h90,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_BYTE,     16'h80,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_BYTE,     16'h80,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_BYTE,     16'h41,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_END,      16'h00,   1'b1, 21'h0,      ST_CAPACITY,  16'd0},
		'{ROW_BYTE,     16'hF4,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_BYTE,     16'h90,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_BYTE,     16'h80,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_BYTE,     16'h80,   1'b0, 21'h0,      ST_OK,        16'd0},
		'{ROW_END,      16'h00,   1'b1, 21'h0,      ST_TOO_BIG,   16'd0}
	};

	utf8_to_utf32_or_utf16_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("%0t ns: %s mismatch, got %0h, expected %0h", $time, field, got, want);
	endtask

	// Queues one unit or a surrogate pair unless the capacity would be reached.
	task automatic queue_units(input int n, input logic [20:0] u0, input logic [20:0] u1);
		logic [16:0] total;
		item_t w;
		total = {1'b0, unit_tally} + 17'(n);
		if (cap_mirror != 16'd0 && total >= {1'b0, cap_mirror}) begin
			err_latched = ST_CAPACITY;
		end else begin
			w = '0;
			w.code_unit = u0;
			w.last_of_run = (n == 1);
			fresh_units.push_back(w);
			if (n == 2) begin
				w.code_unit = u1;
				w.last_of_run = 1'b1;
				fresh_units.push_back(w);
			end
			unit_tally = (total > 17'hFFFF) ? 16'hFFFF : total[15:0];
		end
	endtask

	task automatic close_char(input logic [20:0] cp);
		logic [20:0] offset;
		offset = cp - 21'h10000;
		if (fmt_mirror == FMT_UTF16 && cp > 21'h10FFFF)
			err_latched = ST_TOO_BIG;
		else if (fmt_mirror == FMT_UTF16 && cp > 21'hFFFF)
			queue_units(2, 21'hD800 + (offset >> 10), 21'hDC00 + (cp & 21'h3FF));
		else if (cp >= 21'hD800 && cp < 21'hE000)
			err_latched = ST_SURROGATE;
		else
			queue_units(1, cp, 21'd0);
	endtask

	task automatic decode_word(input logic [7:0] b, input logic end_mark);
		logic [2:0] code;
		item_t w;
		if (end_mark) begin
			code = err_latched;
			if (code == ST_OK && pend_bytes != 2'd0)
				code = ST_TRUNCATED;
			w = '0;
			w.status_item = 1'b1;
			w.status_code = code;
			w.unit_count = (code == ST_OK) ? unit_tally : 16'd0;
			w.last_of_run = 1'b1;
			fresh_units.push_back(w);
			pend_bytes = 2'd0;
			cp_acc = 21'd0;
			err_latched = ST_OK;
			unit_tally = 16'd0;
		end else if (err_latched == ST_OK) begin
			if (pend_bytes == 2'd0) begin
				if (b >= 8'hF0) begin
					cp_acc = {18'd0, b[2:0]};
					pend_bytes = 2'd3;
				end else if (b >= 8'hE0) begin
					cp_acc = {17'd0, b[3:0]};
					pend_bytes = 2'd2;
				end else if (b >= 8'hC0) begin
					cp_acc = {16'd0, b[4:0]};
					pend_bytes = 2'd1;
				end else if (b >= 8'h80) begin
					err_latched = ST_STRAY;
				end else begin
					queue_units(1, {13'd0, b}, 21'd0);
				end
			end else if (b[7:6] != 2'b10) begin
				err_latched = ST_MISSING;
				pend_bytes = 2'd0;
			end else begin
				cp_acc = {cp_acc[14:0], b[5:0]};
				pend_bytes = pend_bytes - 2'd1;
				if (pend_bytes == 2'd0)
					close_char(cp_acc);
			end
		end
	endtask

	always @(posedge clk) begin : result_check
		item_t got;
		item_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				fresh_units.delete();
				decode_word(s_axis_tdata, s_axis_tuser);
				if (drv_pinned)
					expected_units.push_back(drv_typed);
				else
					foreach (fresh_units[i])
						expected_units.push_back(fresh_units[i]);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.code_unit   = m_axis_tdata[20:0];
				got.status_item = m_axis_tuser;
				got.status_code = m_axis_tdata[23:21];
				got.unit_count  = m_axis_tdata[39:24];
				got.last_of_run = m_axis_tlast;
				if (expected_units.size() == 0) begin
					report_mismatch("unexpected word", 32'(got.code_unit), 32'd0);
				end else begin
					want = expected_units.pop_front();
					if (got.code_unit != want.code_unit)
						report_mismatch("code_unit", 32'(got.code_unit),
							32'(want.code_unit));
					if (got.status_item != want.status_item)
						report_mismatch("status_item", 32'(got.status_item),
							32'(want.status_item));
					if (got.status_code != want.status_code)
						report_mismatch("status_code", 32'(got.status_code),
							32'(want.status_code));
					if (got.unit_count != want.unit_count)
						report_mismatch("unit_count", 32'(got.unit_count),
							32'(want.unit_count));
					if (got.last_of_run != want.last_of_run)
						report_mismatch("last_of_run", 32'(got.last_of_run),
							32'(want.last_of_run));
				end
			end
		end
	end

	// Called just after a falling edge; returns just after a falling edge.
	task automatic send_word(input logic [7:0] b, input logic end_mark, input logic pin,
		input item_t typed);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= end_mark;
		drv_pinned <= pin;
		drv_typed <= typed;
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word(b, 1'b0, 1'b0, '0);
	endtask

	function automatic logic [7:0] follow_byte();
		return 8'h80 | 8'($urandom_range(63));
	endfunction

	// Holds the sender off until every outstanding word has come back.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (expected_units.size() != 0);
	endtask

	task automatic set_register(input logic idx, input logic [15:0] value);
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_FORMAT)
			fmt_mirror = value[0];
		else
			cap_mirror = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Mostly well-formed characters of every length, with some stray, broken and raw bytes.
	task automatic send_random_string(input int max_chars);
		int chars;
		int pick;
		logic [7:0] b;
		chars = $urandom_range(max_chars);
		for (int i = 0; i < chars; i++) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				send_byte(8'($urandom_range(127)));
			end else if (pick < 55) begin
				send_byte(8'hC0 | 8'($urandom_range(31)));
				send_byte(follow_byte());
			end else if (pick < 70) begin
				b = ($urandom_range(3) == 0) ? 8'hED : (8'hE0 | 8'($urandom_range(15)));
				send_byte(b);
				send_byte(follow_byte());
				send_byte(follow_byte());
			end else if (pick < 85) begin
				pick = $urandom_range(9);
				if (pick < 6)
					b = 8'hF0 | 8'($urandom_range(3));
				else if (pick < 8)
					b = 8'hF4;
				else
					b = 8'($urandom_range(8'hFF, 8'hF5));
				send_byte(b);
				repeat (3) send_byte(follow_byte());
			end else if (pick < 90) begin
				send_byte(follow_byte());
			end else if (pick < 95) begin
				send_byte(8'($urandom_range(8'hFF, 8'hC0)));
				b = 8'($urandom_range(255));
				if (b[7:6] == 2'b10)
					b[6] = 1'b1;
				send_byte(b);
			end else begin
				send_byte(8'($urandom_range(255)));
			end
		end
		// Now and then the string stops in the middle of a character.
		if ($urandom_range(9) == 0) begin
			send_byte(8'($urandom_range(8'hFF, 8'hC0)));
			if ($urandom_range(1) == 1)
				send_byte(follow_byte());
		end
		send_word(8'($urandom_range(255)), 1'b1, 1'b0, '0);
	endtask

	task automatic run_phase(input logic fmt, input logic [15:0] cap, input int s_pct,
		input int r_pct);
		int start;
		logic paused;
		set_register(REG_FORMAT, {15'd0, fmt});
		set_register(REG_CAPACITY, cap);
		send_idle = s_pct;
		recv_idle = r_pct;
		start = words_sent;
		paused = 1'b0;
		while (words_sent - start < PHASE_WORDS) begin
			send_random_string(12);
			if (!paused && words_sent - start >= PHASE_WORDS / 2) begin
				drain_results();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		stim_row_t row;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		send_idle = 21;
		recv_idle = 78;
		@(negedge clk);

		// The first rows run on the reset values of both registers.
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			case (row.kind)
				ROW_BYTE: send_word(row.value[7:0], 1'b0, row.pinned,
					item_t'{row.unit, 1'b0, row.code, row.count, 1'b1});
				ROW_END: send_word(8'($urandom_range(255)), 1'b1, row.pinned,
					item_t'{row.unit, 1'b1, row.code, row.count, 1'b1});
				ROW_FORMAT: set_register(REG_FORMAT, row.value);
				default: set_register(REG_CAPACITY, row.value);
			endcase
		end

		run_phase(FMT_UTF32, 16'd0, 21, 78);
		run_phase(FMT_UTF16, 16'hFFFF, 21, 78);
		run_phase(FMT_UTF16, 16'($urandom_range(24, 1)), 78, 21);
		run_phase(FMT_UTF32, 16'd1, 78, 21);
		run_phase(FMT_UTF32, 16'($urandom_range(40, 2)), 0, 0);
		run_phase(FMT_UTF16, 16'd0, 0, 0);

		drain_results();
		repeat (4 * SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
